[rtl/salru_pkg.sv]
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and codes of the cache tag and LRU replacement store.
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned WAY_OUT_W = 2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT          = 3'd0,
    OUT_MISS         = 3'd1,
    OUT_FILL_INVALID = 3'd2,
    OUT_FILL_EVICT   = 3'd3,
    OUT_FILL_PRESENT = 3'd4
  } outcome_e;

  // Decision for one access, passed from the update logic to the pipeline.
  typedef struct packed {
    outcome_e outcome;
    logic     wr_en;      // the set row is rewritten
    logic     set_valid;  // the target line becomes valid
  } upd_res_t;

endpackage

`default_nettype wire

[rtl/set_assoc_cache_tags_lru.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_lru
// Tag and LRU replacement store of a set-associative cache: lookups report
// hit or miss, fills of an absent line allocate the first invalid or the least recent way.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_ready_o   func_i, addr_i
//  out      output     out_valid_o / out_ready_i outcome_o, way_o, miss_address_o
//
//  One transfer is accepted per cycle unless the output stalls; each result is
//  registered, the set row being read from memory at the accepting edge.
//  The set row read and its rewrite each have a memory port of their own; a
//  write to the set about to be read is forwarded to the read register.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  A stalled output holds the input register, and in_ready_o falls once that
//  register is occupied as well.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tags_lru #(
  parameter int unsigned SET_CNT     = 64,
  parameter int unsigned WAY_CNT     = 4,
  parameter int unsigned BLOCK_BYTES = 32,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [ADDR_BITS-1:0]            addr_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [salru_pkg::OUTCOME_W-1:0] outcome_o,
  output logic      [salru_pkg::WAY_OUT_W-1:0] way_o,
  output logic      [ADDR_BITS-1:0]            miss_address_o
);
  import salru_pkg::*;

  localparam int unsigned OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int unsigned SET_BITS = $clog2(SET_CNT + 1) - 1;
  localparam int unsigned SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned SET_ROWS = 1 << SET_BITS;
  localparam int unsigned WAY_W    = (WAY_CNT > 1) ? $clog2(WAY_CNT) : 1;
  localparam int          TAG_RAW  = int'(ADDR_BITS) - int'(OFF_BITS) - int'(SET_BITS);
  localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned EXT_W    = ADDR_BITS + OFF_BITS + SET_BITS + TAG_W;
  localparam int unsigned TROW_W   = WAY_CNT * TAG_W;
  localparam int unsigned AROW_W   = WAY_CNT * WAY_W;
  localparam int unsigned ROW_W    = TROW_W + AROW_W;

  // Input register stage
  logic                 s1_valid_q;
  logic                 s1_func_q;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic                 s1_adv;
  logic                 in_acc;

  // Result register stage
  logic                 out_valid_q;
  logic [OUTCOME_W-1:0] outcome_q;
  logic [WAY_OUT_W-1:0] way_q;
  logic [ADDR_BITS-1:0] miss_q;

  logic [WAY_CNT-1:0]   valid_q [SET_ROWS];

  logic [EXT_W-1:0]     in_ext;
  logic [EXT_W-1:0]     s1_ext;
  logic [SET_IW-1:0]    in_set;
  logic [SET_IW-1:0]    s1_set;
  logic [TAG_W-1:0]     s1_tag;

  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     wr_row;
  logic                 wr_en;

  upd_res_t                      res;
  logic [WAY_W-1:0]              tgt_way;
  logic [WAY_CNT-1:0][TAG_W-1:0] new_tags;
  logic [WAY_CNT-1:0][WAY_W-1:0] new_ages;
  logic [WAY_W+WAY_OUT_W-1:0]    way_ext;
  logic [ADDR_BITS-1:0]          blk_addr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Zero padding keeps the set and tag slices inside the word for any sizes.
  assign in_ext = {{(EXT_W - ADDR_BITS){1'b0}}, addr_i};
  assign s1_ext = {{(EXT_W - ADDR_BITS){1'b0}}, s1_addr_q};
  assign in_set = (SET_BITS > 0) ? in_ext[OFF_BITS +: SET_IW] : '0;
  assign s1_set = (SET_BITS > 0) ? s1_ext[OFF_BITS +: SET_IW] : '0;
  assign s1_tag = s1_ext[OFF_BITS + SET_BITS +: TAG_W];

  salru_store #(
    .ROWS  (SET_ROWS),
    .IDX_W (SET_IW),
    .ROW_W (ROW_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (in_set),
    .wr_en_i   (wr_en),
    .wr_idx_i  (s1_set),
    .wr_data_i (wr_row),
    .rd_data_o (rd_row)
  );

  salru_update #(
    .WAY_CNT (WAY_CNT),
    .WAY_W   (WAY_W),
    .TAG_W   (TAG_W)
  ) u_update (
    .fill_i  (s1_func_q),
    .tag_i   (s1_tag),
    .valid_i (valid_q[s1_set]),
    .tags_i  (rd_row[TROW_W-1:0]),
    .ages_i  (rd_row[ROW_W-1:TROW_W]),
    .res_o   (res),
    .way_o   (tgt_way),
    .tags_o  (new_tags),
    .ages_o  (new_ages)
  );

  assign wr_en    = s1_adv && res.wr_en;
  assign wr_row   = {new_ages, new_tags};
  assign way_ext  = {{WAY_OUT_W{1'b0}}, tgt_way};
  assign blk_addr = (s1_addr_q >> OFF_BITS) << OFF_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '{default: '0};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && res.set_valid) begin
        valid_q[s1_set][tgt_way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= func_i;
      s1_addr_q <= addr_i;
    end
    if (s1_adv) begin
      outcome_q <= res.outcome;
      way_q     <= way_ext[WAY_OUT_W-1:0];
      miss_q    <= (res.outcome == OUT_MISS) ? blk_addr : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign way_o          = way_q;
  assign miss_address_o = miss_q;

endmodule

`default_nettype wire

[rtl/salru_store.sv]
// ----------------------------------------------------------------------------
// salru_store
// Row memory holding the tags and recency ranks of every set, with a
// registered read port and write-to-read forwarding for the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_store #(
  parameter int unsigned ROWS  = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned ROW_W = 92
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire logic [ROW_W-1:0] wr_data_i,
  output logic      [ROW_W-1:0] rd_data_o
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] byp_data_q;
  logic             byp_q;
  logic             byp_d;

  // A read that meets a write to the same row on one edge sees the new row.
  assign byp_d = rd_en_i ? (wr_en_i && (wr_idx_i == rd_idx_i)) : byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_idx_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= byp_d;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

[rtl/salru_update.sv]
// ----------------------------------------------------------------------------
// salru_update
// Tag compare, victim choice and recency update for one set.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_update #(
  parameter int unsigned WAY_CNT = 4,
  parameter int unsigned WAY_W   = 2,
  parameter int unsigned TAG_W   = 21
) (
  input  wire logic                          fill_i,
  input  wire logic [TAG_W-1:0]              tag_i,
  input  wire logic [WAY_CNT-1:0]            valid_i,
  input  wire logic [WAY_CNT-1:0][TAG_W-1:0] tags_i,
  input  wire logic [WAY_CNT-1:0][WAY_W-1:0] ages_i,
  output salru_pkg::upd_res_t                res_o,
  output logic      [WAY_W-1:0]              way_o,
  output logic      [WAY_CNT-1:0][TAG_W-1:0] tags_o,
  output logic      [WAY_CNT-1:0][WAY_W-1:0] ages_o
);
  import salru_pkg::*;

  logic                          row_init;
  logic [WAY_CNT-1:0][WAY_W-1:0] cur_age;
  logic                          hit;
  logic [WAY_W-1:0]              hit_way;
  logic                          inv_any;
  logic [WAY_W-1:0]              inv_way;
  logic [WAY_W-1:0]              lru_way;
  logic [WAY_W-1:0]              target;
  logic [WAY_W-1:0]              target_age;

  // A set with no valid line has never been written, so its stored ranks
  // are not yet set; way order stands in for them.
  assign row_init = ~|valid_i;

  always_comb begin
    for (int w = 0; w < WAY_CNT; w++) begin
      cur_age[w] = row_init ? WAY_W'(w) : ages_i[w];
    end
  end

  // Descending scans so that the lowest qualifying way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAY_CNT - 1; w >= 0; w--) begin
      if (valid_i[w] && (tags_i[w] == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
      if (cur_age[w] == WAY_W'(WAY_CNT - 1)) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    res_o.set_valid = fill_i && !hit;
    if (!fill_i) begin
      target = hit_way;
      if (hit) begin
        res_o.outcome = OUT_HIT;
        res_o.wr_en   = 1'b1;
      end else begin
        res_o.outcome = OUT_MISS;
        res_o.wr_en   = 1'b0;
      end
    end else if (hit) begin
      target        = hit_way;
      res_o.outcome = OUT_FILL_PRESENT;
      res_o.wr_en   = 1'b0;
    end else if (inv_any) begin
      target        = inv_way;
      res_o.outcome = OUT_FILL_INVALID;
      res_o.wr_en   = 1'b1;
    end else begin
      target        = lru_way;
      res_o.outcome = OUT_FILL_EVICT;
      res_o.wr_en   = 1'b1;
    end
  end

  assign way_o      = (fill_i || hit) ? target : '0;
  assign target_age = cur_age[target];

  // The target becomes most recent; every younger line ages by one.
  always_comb begin
    for (int w = 0; w < WAY_CNT; w++) begin
      if (WAY_W'(w) == target) begin
        ages_o[w] = '0;
      end else if (cur_age[w] < target_age) begin
        ages_o[w] = cur_age[w] + 1'b1;
      end else begin
        ages_o[w] = cur_age[w];
      end
      tags_o[w] = (fill_i && (WAY_W'(w) == target)) ? tag_i : tags_i[w];
    end
  end

endmodule

`default_nettype wire

[verif/tb_set_assoc_cache_tags_lru.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tags_lru
// Self-checking testbench for the cache tag and LRU replacement store. A
// short table of directed accesses is followed by random lookups and fills
// aimed at a few busy sets, so that hits, invalid-way fills and LRU evictions
// all occur often. Each result is checked against the table or a behavioural
// model of the tag store, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_set_assoc_cache_tags_lru;
  import salru_pkg::*;

  localparam int unsigned SETS         = 64;
  localparam int unsigned WAYS         = 4;
  localparam int unsigned OFFSET_BITS  = 5;
  localparam int unsigned SET_BITS     = 6;
  localparam int unsigned TAG_BITS     = 32 - OFFSET_BITS - SET_BITS;
  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 80;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_FILL   = 1'b1;

  typedef struct packed {
    outcome_e    outcome;
    logic [1:0]  way;
    logic [31:0] miss_address;
  } access_result_t;

  typedef struct packed {
    logic           func;
    logic [31:0]    addr;
    logic           fixed;   // expected result given in the row itself
    access_result_t result;
  } stim_row_t;

  localparam access_result_t FROM_MODEL = '{OUT_HIT, 2'd0, 32'h0};

  // Set 63 is filled through all four ways and then forced to evict; set 0
  // and set 1 cover the low end and the top tag bit.
  localparam stim_row_t DIRECTED [20] = '{
    '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{OUT_MISS, 2'd0, 32'h0000_0000}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{OUT_MISS, 2'd0, 32'hFFFF_FFE0}},
    '{FUNC_FILL,   32'hFFFF_FFFF, 1'b1, '{OUT_FILL_INVALID, 2'd0, 32'h0}},
    '{FUNC_FILL,   32'hFFFF_FFE0, 1'b1, '{OUT_FILL_PRESENT, 2'd0, 32'h0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFE5, 1'b1, '{OUT_HIT, 2'd0, 32'h0}},
    '{FUNC_FILL,   32'h0000_07E0, 1'b1, '{OUT_FILL_INVALID, 2'd1, 32'h0}},
    '{FUNC_FILL,   32'h0000_0FFF, 1'b1, '{OUT_FILL_INVALID, 2'd2, 32'h0}},
    '{FUNC_FILL,   32'h0000_17E0, 1'b1, '{OUT_FILL_INVALID, 2'd3, 32'h0}},
    '{FUNC_FILL,   32'h0000_1FE0, 1'b1, '{OUT_FILL_EVICT, 2'd0, 32'h0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{OUT_MISS, 2'd0, 32'hFFFF_FFE0}},
    '{FUNC_LOOKUP, 32'h0000_07E1, 1'b0, FROM_MODEL},
    '{FUNC_FILL,   32'h0000_07FF, 1'b0, FROM_MODEL},
    '{FUNC_FILL,   32'hFFFF_FFE0, 1'b0, FROM_MODEL},
    '{FUNC_LOOKUP, 32'h0000_0FE0, 1'b0, FROM_MODEL},
    '{FUNC_FILL,   32'h0000_0000, 1'b1, '{OUT_FILL_INVALID, 2'd0, 32'h0}},
    '{FUNC_LOOKUP, 32'h0000_001F, 1'b1, '{OUT_HIT, 2'd0, 32'h0}},
    '{FUNC_LOOKUP, 32'h0000_0800, 1'b1, '{OUT_MISS, 2'd0, 32'h0000_0800}},
    '{FUNC_LOOKUP, 32'h8000_0020, 1'b1, '{OUT_MISS, 2'd0, 32'h8000_0020}},
    '{FUNC_FILL,   32'h8000_0020, 1'b0, FROM_MODEL},
    '{FUNC_LOOKUP, 32'h8000_003F, 1'b0, FROM_MODEL}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        func_i      = 1'b0;
  logic [31:0] addr_i      = 32'h0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [OUTCOME_W-1:0] outcome_o;
  logic [WAY_OUT_W-1:0] way_o;
  logic [31:0]          miss_address_o;

  // Model state of the tag store.
  logic                line_ok    [SETS*WAYS];
  logic [TAG_BITS-1:0] line_tag   [SETS*WAYS];
  logic [1:0]          line_rank  [SETS*WAYS];

  access_result_t pending_outcomes [$];
  int unsigned    fail_count   = 0;
  int unsigned    inputs_taken = 0;
  int unsigned    results_seen = 0;

  always #1 clk_i = ~clk_i;

  set_assoc_cache_tags_lru DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .addr_i         (addr_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .outcome_o      (outcome_o),
    .way_o          (way_o),
    .miss_address_o (miss_address_o)
  );

  // The line takes rank 0 and every more recent line of its set ages by one.
  function automatic void make_most_recent(input int unsigned base, input int unsigned w);
    logic [1:0] old_rank;
    old_rank = line_rank[base + w];
    for (int v = 0; v < WAYS; v++) begin
      if (line_rank[base + v] < old_rank) line_rank[base + v] = line_rank[base + v] + 2'd1;
    end
    line_rank[base + w] = 2'd0;
  endfunction

  function automatic access_result_t predict_access(input logic f, input logic [31:0] a);
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;
    int unsigned         base;
    int                  hit_way;
    int                  victim;
    access_result_t      r;
    set_idx = a[OFFSET_BITS +: SET_BITS];
    tag     = a[31 -: TAG_BITS];
    base    = set_idx * WAYS;
    hit_way = -1;
    r       = FROM_MODEL;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_way < 0 && line_ok[base + w] && line_tag[base + w] == tag) hit_way = w;
    end
    if (f == FUNC_LOOKUP) begin
      if (hit_way >= 0) begin
        make_most_recent(base, hit_way);
        r.outcome = OUT_HIT;
        r.way     = hit_way[1:0];
      end else begin
        r.outcome      = OUT_MISS;
        r.miss_address = {a[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
      end
    end else if (hit_way >= 0) begin
      r.outcome = OUT_FILL_PRESENT;
      r.way     = hit_way[1:0];
    end else begin
      victim = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (victim < 0 && !line_ok[base + w]) victim = w;
      end
      if (victim >= 0) begin
        r.outcome = OUT_FILL_INVALID;
      end else begin
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (line_rank[base + w] > line_rank[base + victim]) victim = w;
        end
        r.outcome = OUT_FILL_EVICT;
      end
      line_ok[base + victim]  = 1'b1;
      line_tag[base + victim] = tag;
      make_most_recent(base, victim);
      r.way = victim[1:0];
    end
    return r;
  endfunction

  // Offers one access and records its expected result once the transfer is
  // taken. Valid stays high straight into the next access when no gap is drawn.
  task automatic offer_access(input logic f, input logic [31:0] a, input logic fixed,
                              input access_result_t given);
    int unsigned    gap;
    access_result_t predicted;
    gap = (((inputs_taken / 40) % 4) == 3) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    addr_i     <= a;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_access(f, a);
    pending_outcomes.push_back(fixed ? given : predicted);
    inputs_taken++;
  endtask

  initial begin : stimulus
    logic [TAG_BITS-1:0] tag_pool [6];
    logic [SET_BITS-1:0] busy_sets [3];
    logic                f;
    logic [31:0]         a;
    for (int i = 0; i < SETS * WAYS; i++) begin
      line_ok[i]   = 1'b0;
      line_tag[i]  = '0;
      line_rank[i] = 2'(i % WAYS);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      offer_access(DIRECTED[i].func, DIRECTED[i].addr, DIRECTED[i].fixed, DIRECTED[i].result);
    end

    // Mostly accesses to a few busy sets with a handful of tags each, so that
    // sets fill up and evict; the remainder are fully random accesses.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 96 == 0) begin
        foreach (tag_pool[k]) tag_pool[k] = TAG_BITS'($urandom);
        foreach (busy_sets[k]) busy_sets[k] = SET_BITS'($urandom_range(0, SETS - 1));
      end
      if ($urandom_range(0, 9) < 8) begin
        f = ($urandom_range(0, 4) < 2) ? FUNC_FILL : FUNC_LOOKUP;
        a = {tag_pool[$urandom_range(0, 5)], busy_sets[$urandom_range(0, 2)],
             OFFSET_BITS'($urandom)};
      end else begin
        f = 1'($urandom);
        a = $urandom;
      end
      offer_access(f, a, 1'b0, FROM_MODEL);
    end
    in_valid_i <= 1'b0;

    wait (pending_outcomes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off so
  // that the pipeline fills and the input side backs up.
  initial begin : result_sink
    int unsigned stall;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && inputs_taken >= 300) begin
        stall          = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (((results_seen / 40) % 4) == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no access outstanding: outcome %0d way %0d miss 0x%08h",
               outcome_o, way_o, miss_address_o);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome: expected %0d actual %0d", want.outcome, outcome_o);
          fail_count++;
        end
        if (way_o !== want.way) begin
          $error("way: expected %0d actual %0d", want.way, way_o);
          fail_count++;
        end
        if (miss_address_o !== want.miss_address) begin
          $error("miss_address: expected 0x%08h actual 0x%08h",
                 want.miss_address, miss_address_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
